>>> hdl/ms4_pkg.sv
`default_nettype none
package ms4_pkg;

  localparam int MAX_GRID = 512;
  localparam int COORD_W  = $clog2(MAX_GRID);
  localparam int SIZE_W   = 10;

  localparam logic [7:0] CELL_CLEAR = 8'h00;
  localparam logic [7:0] CELL_FULL  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_INTERIOR,
    KIND_RIGHT,
    KIND_BOTTOM,
    KIND_CORNER
  } kind_t;

  // index bits: tl=8, tr=4, bl=2, br=1; entry [i][0] is the top row
  localparam logic [31:0] BLOCK_TABLE [16][4] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
    '{32'h00000000, 32'h00000000, 32'h80000000, 32'hFF800000},
    '{32'h00000000, 32'h00000000, 32'h00000080, 32'h000080FF},
    '{32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{32'hFF800000, 32'h80000000, 32'h00000000, 32'h00000000},
    '{32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000, 32'hFFFF0000},
    '{32'hFF800000, 32'h80000000, 32'h00000080, 32'h000080FF},
    '{32'hFFFF8000, 32'hFFFFFF80, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{32'h000080FF, 32'h00000080, 32'h00000000, 32'h00000000},
    '{32'h000080FF, 32'h00000080, 32'h80000000, 32'hFF800000},
    '{32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF},
    '{32'h0080FFFF, 32'h80FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF80, 32'hFFFF8000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80FFFFFF, 32'h0080FFFF},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}
  };

endpackage
`default_nettype wire

>>> hdl/ms4_if.sv
`default_nettype none
interface ms4_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface ms4_cfg_if import ms4_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] grid_size;

  modport source (output valid, output grid_size, input ready);
  modport sink (input valid, input grid_size, output ready);
endinterface

interface ms4_block_if import ms4_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] block_x;
  logic [COORD_W-1:0] block_y;
  logic               matched;
  logic [31:0]        texel_row0;
  logic [31:0]        texel_row1;
  logic [31:0]        texel_row2;
  logic [31:0]        texel_row3;
  logic               last_of_run;

  modport source (
    output valid, output block_x, output block_y, output matched,
    output texel_row0, output texel_row1, output texel_row2, output texel_row3,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input block_x, input block_y, input matched,
    input texel_row0, input texel_row1, input texel_row2, input texel_row3,
    input last_of_run, output ready
  );
endinterface
`default_nettype wire

>>> hdl/marching_squares_upscale_4x.sv
`default_nettype none
// 4x marching-squares upscaler. Grid cells come in raster order on cells, one request per
// cycle while cells.ready is high; a 512x8 line store (one read and one write per cycle) holds
// the previous row. Each cell is registered with its line-store read, then one block a cycle,
// unless blocks stalls, is formed from the 2x2 corner table into an output register. Interior
// cells emit at most one block and sustain one cell per cycle unless blocks stalls; a cell in
// the last column or last row emits up to two blocks, the frame's last cell up to four (right and
// bottom edges clamped), and holds cells.ready low until its last block is loaded. A cfg write
// sets the grid size (0 as 1, above 512 as 512) and restarts the frame; it is always ready.
module marching_squares_upscale_4x import ms4_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  ms4_cfg_if.sink       cfg,
  ms4_cell_if.sink      cells,
  ms4_block_if.source   blocks
);

  logic [SIZE_W-1:0]  gsz;
  logic [SIZE_W-1:0]  geff;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               accept;
  logic               lastc;
  logic               lastr;

  logic [7:0]         above_mem [MAX_GRID];
  logic [7:0]         above_rd;

  logic               s1_valid;
  logic [7:0]         s1_cell;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_lastc;
  logic               s1_lastr;
  logic [7:0]         left_cell;
  logic [7:0]         above_left;

  logic [3:0]         need;
  logic [3:0]         done;
  logic [3:0]         pending;
  logic [3:0]         pick;
  kind_t              kind;
  logic               pick_last;
  logic               load;
  logic               s1_finish;

  logic [7:0]         tl, tr, bl, br;
  logic [COORD_W-1:0] bx, by;
  logic               ok;
  logic [3:0]         tidx;

  assign cfg.ready   = 1'b1;
  assign accept      = cells.valid && cells.ready;
  assign cells.ready = !s1_valid || s1_finish;

  always_comb begin
    if (gsz == '0) begin
      geff = SIZE_W'(1);
    end else if (gsz > SIZE_W'(MAX_GRID)) begin
      geff = SIZE_W'(MAX_GRID);
    end else begin
      geff = gsz;
    end
  end

  assign lastc = (SIZE_W'(col) + SIZE_W'(1)) >= geff;
  assign lastr = (SIZE_W'(row) + SIZE_W'(1)) >= geff;

  always_ff @(posedge clk) begin
    if (rst) begin
      gsz <= SIZE_W'(MAX_GRID);
      col <= '0;
      row <= '0;
    end else if (cfg.valid && cfg.ready) begin
      gsz <= cfg.grid_size;
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (lastc) begin
        col <= '0;
        row <= lastr ? '0 : row + COORD_W'(1);
      end else begin
        col <= col + COORD_W'(1);
      end
    end
  end

  // read-first: the old row entry comes out while the new cell replaces it
  always_ff @(posedge clk) begin
    if (accept) begin
      above_rd       <= above_mem[col];
      above_mem[col] <= cells.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_finish) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell  <= cells.cell_value;
      s1_col   <= col;
      s1_row   <= row;
      s1_lastc <= lastc;
      s1_lastr <= lastr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cell  <= '0;
      above_left <= '0;
    end else if (s1_finish) begin
      left_cell  <= s1_cell;
      above_left <= above_rd;
    end
  end

  // blocks owed by the registered cell, in emission order
  assign need[0] = (s1_row != '0) && (s1_col != '0);
  assign need[1] = (s1_row != '0) && s1_lastc;
  assign need[2] = s1_lastr && (s1_col != '0);
  assign need[3] = s1_lastr && s1_lastc;

  assign pending   = need & ~done;
  assign pick      = pending & (~pending + 4'd1);
  assign pick_last = (pending & ~pick) == '0;
  assign load      = s1_valid && (pending != '0) && (!blocks.valid || blocks.ready);
  assign s1_finish = s1_valid && ((pending == '0) || (load && pick_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (s1_finish) begin
      done <= '0;
    end else if (load) begin
      done <= done | pick;
    end
  end

  always_comb begin
    if (pick[0]) begin
      kind = KIND_INTERIOR;
    end else if (pick[1]) begin
      kind = KIND_RIGHT;
    end else if (pick[2]) begin
      kind = KIND_BOTTOM;
    end else begin
      kind = KIND_CORNER;
    end
  end

  always_comb begin
    case (kind)
      KIND_INTERIOR: begin
        tl = above_left;
        tr = above_rd;
        bl = left_cell;
        br = s1_cell;
        bx = s1_col - COORD_W'(1);
        by = s1_row - COORD_W'(1);
      end
      KIND_RIGHT: begin
        tl = above_rd;
        tr = above_rd;
        bl = s1_cell;
        br = s1_cell;
        bx = s1_col;
        by = s1_row - COORD_W'(1);
      end
      KIND_BOTTOM: begin
        tl = left_cell;
        tr = s1_cell;
        bl = left_cell;
        br = s1_cell;
        bx = s1_col - COORD_W'(1);
        by = s1_row;
      end
      default: begin
        tl = s1_cell;
        tr = s1_cell;
        bl = s1_cell;
        br = s1_cell;
        bx = s1_col;
        by = s1_row;
      end
    endcase
  end

  assign ok = ((tl == CELL_CLEAR) || (tl == CELL_FULL)) &&
              ((tr == CELL_CLEAR) || (tr == CELL_FULL)) &&
              ((bl == CELL_CLEAR) || (bl == CELL_FULL)) &&
              ((br == CELL_CLEAR) || (br == CELL_FULL));
  assign tidx = {tl != CELL_CLEAR, tr != CELL_CLEAR, bl != CELL_CLEAR, br != CELL_CLEAR};

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks.valid <= 1'b0;
    end else if (load) begin
      blocks.valid <= 1'b1;
    end else if (blocks.ready) begin
      blocks.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blocks.block_x     <= bx;
      blocks.block_y     <= by;
      blocks.matched     <= ok;
      blocks.texel_row0  <= ok ? BLOCK_TABLE[tidx][0] : '0;
      blocks.texel_row1  <= ok ? BLOCK_TABLE[tidx][1] : '0;
      blocks.texel_row2  <= ok ? BLOCK_TABLE[tidx][2] : '0;
      blocks.texel_row3  <= ok ? BLOCK_TABLE[tidx][3] : '0;
      blocks.last_of_run <= pick_last;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (SIZE_W'(col) < geff) && (SIZE_W'(row) < geff))
    else $error("cell position outside grid");

  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((done & ~need) == '0))
    else $error("block marked done that the cell does not owe");

  a_last_retires: assert property (@(posedge clk) disable iff (rst)
    (load && pick_last) |=> (done == '0) && blocks.valid && blocks.last_of_run)
    else $error("last block did not retire its cell");
`endif

endmodule
`default_nettype wire
